// ===== sv/lprfp_pkg.sv =====
// shared types and codes for the length-prefixed record field parser
// no dependencies; used by the parse core, the top level and the checker
package lprfp_pkg;

  localparam logic [7:0] EQ_CHAR = 8'h3D;

  // parse phases
  localparam logic [2:0] PH_HDRLEN = 3'd0;
  localparam logic [2:0] PH_FLDLEN = 3'd1;
  localparam logic [2:0] PH_NAME   = 3'd2;
  localparam logic [2:0] PH_VALUE  = 3'd3;
  localparam logic [2:0] PH_DATLEN = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;

  // byte kinds
  localparam logic [2:0] K_HDRLEN = 3'd0;
  localparam logic [2:0] K_FLDLEN = 3'd1;
  localparam logic [2:0] K_NAME   = 3'd2;
  localparam logic [2:0] K_EQ     = 3'd3;
  localparam logic [2:0] K_VALUE  = 3'd4;
  localparam logic [2:0] K_DATLEN = 3'd5;
  localparam logic [2:0] K_DATA   = 3'd6;
  localparam logic [2:0] K_DISC   = 3'd7;

  // error codes
  localparam logic [2:0] E_NONE   = 3'd0;
  localparam logic [2:0] E_SHORT  = 3'd1;
  localparam logic [2:0] E_BADLEN = 3'd2;
  localparam logic [2:0] E_NOEQ   = 3'd3;
  localparam logic [2:0] E_TRUNC  = 3'd4;

  typedef struct packed {
    logic [2:0] byte_kind;
    logic [7:0] out_byte;
    logic       field_end;
    logic       record_end;
    logic [2:0] error_code;
  } lprfp_result_t;

endpackage

// ===== sv/lprfp_parse.sv =====
// parse state and per-byte labeling logic
// depends on lprfp_pkg; state commits only on the cycle the byte moves on
module lprfp_parse #(
  parameter int LEN_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic [7:0]               in_byte,
  input  logic                     in_last,
  output lprfp_pkg::lprfp_result_t result
);

  logic [2:0]          phase, phase_next;
  logic [23:0]         length_shift, length_shift_next;
  logic [1:0]          length_byte_count, length_byte_count_next;
  logic [LEN_BITS-1:0] header_left, header_left_next;
  logic [LEN_BITS-1:0] field_left, field_left_next;
  logic [LEN_BITS-1:0] data_left, data_left_next;
  logic                equals_seen, equals_seen_next;
  logic [2:0]          sticky_error, sticky_error_next;

  logic [2:0]          ph;
  logic                len_done;
  logic [31:0]         len_raw;
  logic [LEN_BITS-1:0] len_val;
  logic [LEN_BITS-1:0] hl_dec, fl_dec, dl_dec;
  logic                is_eq, eq_now;
  logic [2:0]          kind, err;
  logic                fend, rend;

  assign ph       = (phase > lprfp_pkg::PH_DATA) ? lprfp_pkg::PH_HDRLEN : phase;
  assign len_done = (length_byte_count == 2'd3);
  assign len_raw  = {in_byte, length_shift};
  // saturate lengths that do not fit the counters
  assign len_val  = ((len_raw >> LEN_BITS) != 32'd0) ? {LEN_BITS{1'b1}}
                                                     : len_raw[LEN_BITS-1:0];
  assign hl_dec = (header_left != '0) ? header_left - 1'b1 : header_left;
  assign fl_dec = (field_left != '0) ? field_left - 1'b1 : field_left;
  assign dl_dec = (data_left != '0) ? data_left - 1'b1 : data_left;
  assign is_eq  = (ph == lprfp_pkg::PH_NAME) && (in_byte == lprfp_pkg::EQ_CHAR);
  assign eq_now = equals_seen | is_eq;

  always_comb begin
    phase_next             = phase;
    length_shift_next      = length_shift;
    length_byte_count_next = length_byte_count;
    header_left_next       = header_left;
    field_left_next        = field_left;
    data_left_next         = data_left;
    equals_seen_next       = equals_seen;
    sticky_error_next      = sticky_error;
    kind                   = lprfp_pkg::K_DISC;
    err                    = lprfp_pkg::E_NONE;
    fend                   = 1'b0;
    rend                   = 1'b0;

    if (sticky_error == lprfp_pkg::E_NONE) begin
      // shared length assembly, used by the three length phases
      if (len_done) begin
        length_shift_next      = '0;
        length_byte_count_next = 2'd0;
      end else begin
        case (length_byte_count)
          2'd0:    length_shift_next[7:0]   = in_byte;
          2'd1:    length_shift_next[15:8]  = in_byte;
          default: length_shift_next[23:16] = in_byte;
        endcase
        length_byte_count_next = length_byte_count + 2'd1;
      end

      case (ph)
        lprfp_pkg::PH_HDRLEN: begin
          kind = lprfp_pkg::K_HDRLEN;
          if (len_done) begin
            header_left_next = len_val;
            phase_next = (len_val == '0) ? lprfp_pkg::PH_DATLEN : lprfp_pkg::PH_FLDLEN;
          end
        end
        lprfp_pkg::PH_FLDLEN: begin
          kind = lprfp_pkg::K_FLDLEN;
          if (length_byte_count == 2'd0 && header_left < LEN_BITS'(4)) begin
            err                    = lprfp_pkg::E_SHORT;
            length_shift_next      = length_shift;
            length_byte_count_next = length_byte_count;
          end else begin
            header_left_next = hl_dec;
            if (len_done) begin
              if (len_val == '0 || len_val > hl_dec) begin
                err = lprfp_pkg::E_BADLEN;
              end else begin
                field_left_next  = len_val;
                equals_seen_next = 1'b0;
                phase_next       = lprfp_pkg::PH_NAME;
              end
            end
          end
        end
        lprfp_pkg::PH_NAME, lprfp_pkg::PH_VALUE: begin
          length_shift_next      = length_shift;
          length_byte_count_next = length_byte_count;
          if (is_eq) begin
            kind             = lprfp_pkg::K_EQ;
            equals_seen_next = 1'b1;
            phase_next       = lprfp_pkg::PH_VALUE;
          end else begin
            kind = (ph == lprfp_pkg::PH_NAME) ? lprfp_pkg::K_NAME : lprfp_pkg::K_VALUE;
          end
          field_left_next  = fl_dec;
          header_left_next = hl_dec;
          if (fl_dec == '0) begin
            fend = 1'b1;
            if (!eq_now) begin
              err = lprfp_pkg::E_NOEQ;
            end else begin
              phase_next = (hl_dec == '0) ? lprfp_pkg::PH_DATLEN : lprfp_pkg::PH_FLDLEN;
            end
          end
        end
        lprfp_pkg::PH_DATLEN: begin
          kind = lprfp_pkg::K_DATLEN;
          if (len_done) begin
            if (len_val == '0) begin
              rend       = 1'b1;
              phase_next = lprfp_pkg::PH_HDRLEN;
            end else begin
              data_left_next = len_val;
              phase_next     = lprfp_pkg::PH_DATA;
            end
          end
        end
        default: begin
          kind                   = lprfp_pkg::K_DATA;
          length_shift_next      = length_shift;
          length_byte_count_next = length_byte_count;
          data_left_next         = dl_dec;
          if (dl_dec == '0) begin
            rend       = 1'b1;
            phase_next = lprfp_pkg::PH_HDRLEN;
          end
        end
      endcase

      // a stream that stops mid-record, unless this byte already failed
      if (err == lprfp_pkg::E_NONE && in_last && !rend) begin
        err = lprfp_pkg::E_TRUNC;
      end
      sticky_error_next = err;
    end
  end

  assign result.byte_kind  = kind;
  assign result.out_byte   = in_byte;
  assign result.field_end  = fend;
  assign result.record_end = rend;
  assign result.error_code = sticky_error_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= lprfp_pkg::PH_HDRLEN;
      length_shift      <= '0;
      length_byte_count <= 2'd0;
      header_left       <= '0;
      field_left        <= '0;
      data_left         <= '0;
      equals_seen       <= 1'b0;
      sticky_error      <= lprfp_pkg::E_NONE;
    end else if (advance) begin
      phase             <= phase_next;
      length_shift      <= length_shift_next;
      length_byte_count <= length_byte_count_next;
      header_left       <= header_left_next;
      field_left        <= field_left_next;
      data_left         <= data_left_next;
      equals_seen       <= equals_seen_next;
      sticky_error      <= sticky_error_next;
    end
  end

endmodule

// ===== sv/length_prefixed_record_field_parser.sv =====
// Labels a stream of length-prefixed key/value records one byte per cycle.
// Each accepted byte enters an input register, is labeled by the parse core
// against the running record state and lands in an output register; a new
// beat is taken every cycle while the master side keeps up. Length counters
// are LEN_BITS wide; longer lengths saturate. Errors stick until reset and
// turn every later byte into a discarded one.
// depends on lprfp_pkg and lprfp_parse
module length_prefixed_record_field_parser #(
  parameter int LEN_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // stream_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
  output logic [3:0]  m_tuser,   // [2:0] byte_kind, [3] field_end
  output logic        m_tlast    // record_end
);

  logic                     in_valid;
  logic [7:0]               in_byte;
  logic                     in_last;
  logic                     advance;
  lprfp_pkg::lprfp_result_t res;
  lprfp_pkg::lprfp_result_t out_res;
  logic                     out_valid;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  lprfp_parse #(.LEN_BITS(LEN_BITS)) u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_byte (in_byte),
    .in_last (in_last),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_res.error_code, out_res.out_byte};
  assign m_tuser  = {out_res.field_end, out_res.byte_kind};
  assign m_tlast  = out_res.record_end;

endmodule

// ===== sv/lprfp_checker.sv =====
// port-level checks for the record field parser, bound to the top level
// depends on lprfp_pkg
module lprfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [3:0]  m_tuser,
  input logic        m_tlast
);

  logic       out_beat;
  logic [2:0] last_err;

  assign out_beat = m_tvalid && m_tready;

  // error code of the latest delivered beat
  always_ff @(posedge clk) begin
    if (rst) begin
      last_err <= lprfp_pkg::E_NONE;
    end else if (out_beat) begin
      last_err <= m_tdata[10:8];
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled output beat changed");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_beat && last_err != lprfp_pkg::E_NONE |->
      m_tdata[10:8] == last_err && m_tuser[2:0] == lprfp_pkg::K_DISC)
    else $error("error code not sticky");

  a_disc: assert property (@(posedge clk) disable iff (rst)
    out_beat && m_tuser[2:0] == lprfp_pkg::K_DISC |-> m_tdata[10:8] != lprfp_pkg::E_NONE
      && !m_tuser[3] && !m_tlast)
    else $error("discarded beat without error");

  a_fend: assert property (@(posedge clk) disable iff (rst)
    out_beat && m_tuser[3] |-> m_tuser[2:0] == lprfp_pkg::K_NAME
      || m_tuser[2:0] == lprfp_pkg::K_EQ || m_tuser[2:0] == lprfp_pkg::K_VALUE)
    else $error("field end outside a field");

  a_rend: assert property (@(posedge clk) disable iff (rst)
    out_beat && m_tlast |-> m_tdata[10:8] == lprfp_pkg::E_NONE
      && (m_tuser[2:0] == lprfp_pkg::K_DATLEN || m_tuser[2:0] == lprfp_pkg::K_DATA))
    else $error("record end on a bad beat");

endmodule

bind length_prefixed_record_field_parser lprfp_checker u_lprfp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
